/* sv/ptfa_pkg.sv */
// Types, codes and default sizes shared by the paged translation frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package ptfa_pkg;

	localparam int PROCESSES_DEF   = 4;
	localparam int OFFSET_BITS_DEF = 12;
	localparam int VADDR_BITS_DEF  = 16;
	localparam int PADDR_BITS_DEF  = 18;

	localparam int PID_FIELD_W   = 2;
	localparam int VADDR_FIELD_W = 16;
	localparam int FRAME_FIELD_W = 6;
	localparam int PADDR_FIELD_W = 18;

	typedef enum logic [1:0] {
		ACT_PRESET  = 2'd0,
		ACT_MAP     = 2'd1,
		ACT_XLATE   = 2'd2,
		ACT_RELEASE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_NO_FRAME = 2'd2,
		ST_MAPPED   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_XLAT,
		S_REL_RD,
		S_REL_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		action_t                    action;
		logic [PID_FIELD_W-1:0]     process_id;
		logic [VADDR_FIELD_W-1:0]   virtual_address;
		logic [FRAME_FIELD_W-1:0]   frame_index;
		logic                       frame_busy;
	} req_t;

	typedef struct packed {
		status_t                    status;
		logic [PADDR_FIELD_W-1:0]   physical_address;
		logic [FRAME_FIELD_W-1:0]   assigned_frame;
	} rsp_t;

endpackage
`default_nettype wire

/* sv/paged_translation_frame_allocator.sv */
// Page table with first-fit frame bitmap: preset, map, translate and release requests.
// Preset, map of a mapped page and requests of an out-of-range process go from S_EXEC straight
// to S_DONE; translate passes through S_XLAT; map scans in S_SCAN from frame 0, one bitmap bit
// a cycle, for the first free frame; release alternates S_REL_RD and S_REL_WR over every page
// of the process. One request at a time, accepted the cycle after the result is registered.
// Reset clears the sequencer, output valid, frame busy and page valid bits, not the frame RAM.
`timescale 1ns / 1ps
`default_nettype none
module paged_translation_frame_allocator #(
	parameter int PROCESSES   = ptfa_pkg::PROCESSES_DEF,
	parameter int OFFSET_BITS = ptfa_pkg::OFFSET_BITS_DEF,
	parameter int VADDR_BITS  = ptfa_pkg::VADDR_BITS_DEF,
	parameter int PADDR_BITS  = ptfa_pkg::PADDR_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  wire ptfa_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output ptfa_pkg::rsp_t       rsp
);

	localparam int PAGE_W  = VADDR_BITS - OFFSET_BITS;
	localparam int FRAME_W = PADDR_BITS - OFFSET_BITS;
	localparam int PAGES   = 1 << PAGE_W;
	localparam int FRAMES  = 1 << FRAME_W;
	localparam int ENTRIES = PROCESSES * PAGES;
	localparam int EIDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	ptfa_pkg::state_t state_q, state_d;
	ptfa_pkg::req_t   req_q;
	ptfa_pkg::rsp_t   res_q, res_d;
	ptfa_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	logic [FRAME_W-1:0] scan_q, scan_d;
	logic [PAGE_W-1:0]  idx_q, idx_d;
	logic [FRAMES-1:0]  fiu_q, fiu_d;
	logic [ENTRIES-1:0] pv_q, pv_d;

	logic [FRAME_W-1:0] frame_mem [ENTRIES];
	logic [FRAME_W-1:0] rd_frame_q;
	logic               mem_we;
	logic [EIDX_W-1:0]  mem_raddr;

	logic [31:0]        vaddr_w;
	logic [PAGE_W-1:0]  page;
	logic [EIDX_W-1:0]  req_entry, rel_entry;
	logic               pid_ok, frame_ok;
	logic               accept, rsp_load;
	logic [PADDR_BITS-1:0] paddr;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ptfa_pkg::S_IDLE);
	assign rsp_load  = (state_q == ptfa_pkg::S_DONE) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign vaddr_w   = 32'(req_q.virtual_address);
	assign page      = PAGE_W'(vaddr_w >> OFFSET_BITS);
	assign pid_ok    = 32'(req_q.process_id) < PROCESSES;
	assign frame_ok  = 32'(req_q.frame_index) < FRAMES;
	assign req_entry = EIDX_W'(32'(req_q.process_id) * 32'(PAGES) + 32'(page));
	assign rel_entry = EIDX_W'(32'(req_q.process_id) * 32'(PAGES) + 32'(idx_q));
	assign paddr     = {rd_frame_q, vaddr_w[OFFSET_BITS-1:0]};
	assign mem_raddr = (state_q == ptfa_pkg::S_EXEC) ? req_entry : rel_entry;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		scan_d  = scan_q;
		idx_d   = idx_q;
		fiu_d   = fiu_q;
		pv_d    = pv_q;
		mem_we  = 1'b0;
		case (state_q)
			ptfa_pkg::S_IDLE: begin
				if (accept) begin
					state_d = ptfa_pkg::S_EXEC;
				end
			end
			ptfa_pkg::S_EXEC: begin
				res_d   = '0;
				scan_d  = '0;
				idx_d   = '0;
				state_d = ptfa_pkg::S_DONE;
				if (req_q.action == ptfa_pkg::ACT_PRESET) begin
					if (frame_ok) begin
						fiu_d[FRAME_W'(req_q.frame_index)] = req_q.frame_busy;
					end
				end else if (!pid_ok) begin
					if (req_q.action != ptfa_pkg::ACT_RELEASE) begin
						res_d.status = ptfa_pkg::ST_INVALID;
					end
				end else begin
					case (req_q.action)
						ptfa_pkg::ACT_MAP: begin
							if (pv_q[req_entry]) begin
								res_d.status = ptfa_pkg::ST_MAPPED;
							end else begin
								state_d = ptfa_pkg::S_SCAN;
							end
						end
						ptfa_pkg::ACT_XLATE: begin
							if (pv_q[req_entry]) begin
								state_d = ptfa_pkg::S_XLAT;
							end else begin
								res_d.status = ptfa_pkg::ST_INVALID;
							end
						end
						ptfa_pkg::ACT_RELEASE: begin
							state_d = ptfa_pkg::S_REL_RD;
						end
						default: begin
							state_d = ptfa_pkg::S_DONE;
						end
					endcase
				end
			end
			ptfa_pkg::S_SCAN: begin
				if (!fiu_q[scan_q]) begin
					fiu_d[scan_q]           = 1'b1;
					pv_d[req_entry]         = 1'b1;
					mem_we                  = 1'b1;
					res_d.assigned_frame    = ptfa_pkg::FRAME_FIELD_W'(scan_q);
					state_d                 = ptfa_pkg::S_DONE;
				end else if (&scan_q) begin
					res_d.status = ptfa_pkg::ST_NO_FRAME;
					state_d      = ptfa_pkg::S_DONE;
				end else begin
					scan_d = scan_q + FRAME_W'(1);
				end
			end
			ptfa_pkg::S_XLAT: begin
				res_d.physical_address = ptfa_pkg::PADDR_FIELD_W'(paddr);
				state_d                = ptfa_pkg::S_DONE;
			end
			ptfa_pkg::S_REL_RD: begin
				state_d = ptfa_pkg::S_REL_WR;
			end
			ptfa_pkg::S_REL_WR: begin
				if (pv_q[rel_entry]) begin
					fiu_d[rd_frame_q] = 1'b0;
					pv_d[rel_entry]   = 1'b0;
				end
				if (&idx_q) begin
					state_d = ptfa_pkg::S_DONE;
				end else begin
					idx_d   = idx_q + PAGE_W'(1);
					state_d = ptfa_pkg::S_REL_RD;
				end
			end
			ptfa_pkg::S_DONE: begin
				if (rsp_load) begin
					state_d = ptfa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ptfa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptfa_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
			fiu_q       <= '0;
			pv_q        <= '0;
		end else begin
			state_q <= state_d;
			fiu_q   <= fiu_d;
			pv_q    <= pv_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
		res_q  <= res_d;
		scan_q <= scan_d;
		idx_q  <= idx_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[req_entry] <= scan_q;
		end
		rd_frame_q <= frame_mem[mem_raddr];
	end

`ifndef SYNTH
	a_map_claims_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptfa_pkg::S_SCAN && !fiu_q[scan_q]) |=> fiu_q[$past(scan_q)])
		else $error("map did not mark its frame busy");

	a_map_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptfa_pkg::S_SCAN && !fiu_q[scan_q]) |=> pv_q[$past(req_entry)])
		else $error("map did not validate its page entry");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptfa_pkg::S_REL_WR) |=> !pv_q[$past(rel_entry)])
		else $error("release left a page entry valid");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ptfa_pkg::S_DONE)
		else $error("response raised outside the done state");
`endif

endmodule
`default_nettype wire
